// ===== hdl/edmt_pkg.sv =====
package edmt_pkg;

  localparam int FLOOR_W = 10;
  localparam int EGG_W   = 4;
  localparam int TRIAL_W = 10;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor_count;
    logic [EGG_W-1:0]   egg_count;
  } query_t;

  typedef struct packed {
    logic [TRIAL_W-1:0] min_trials;
    logic               invalid;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_status_t;

endpackage

// ===== hdl/edmt_table.sv =====
module edmt_table import edmt_pkg::*; #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [TRIAL_W-1:0] wdata,
  input  logic               rd_en,
  input  logic [AW-1:0]      raddr_a,
  input  logic [AW-1:0]      raddr_b,
  output logic [TRIAL_W-1:0] rdata_a,
  output logic [TRIAL_W-1:0] rdata_b
);

  logic [TRIAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/edmt_engine.sv =====
module edmt_engine import edmt_pkg::*; #(
  parameter int unsigned MAX_FLOORS = 1023,
  parameter int unsigned MAX_EGGS   = 15,
  parameter int          FW         = 10,
  parameter int          EW         = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [FW-1:0]      floors_in,
  input  logic [EW-1:0]      eggs_in,
  output eng_status_t        status,
  output logic [TRIAL_W-1:0] trials
);

  localparam int ROW   = int'(MAX_FLOORS) + 1;
  localparam int DEPTH = (int'(MAX_EGGS) + 1) * ROW;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_LINEAR, S_FILL, S_WAIT} state_t;

  state_t             state;
  logic [FW-1:0]      floors;
  logic [EW-1:0]      eggs;
  logic [EW-1:0]      e;
  logic [FW-1:0]      n;
  logic [FW-1:0]      f;
  logic [TRIAL_W:0]   best;
  logic               rd_vld;
  logic               done;

  logic [FW-1:0]      lin_end;
  logic               we;
  logic               rd_en;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic [TRIAL_W-1:0] wdata;
  logic [TRIAL_W-1:0] rdata_a;
  logic [TRIAL_W-1:0] rdata_b;
  logic [TRIAL_W:0]   worst;
  logic [TRIAL_W:0]   best_cand;

  edmt_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .rd_en   (rd_en),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    lin_end   = (e == EW'(1)) ? floors : FW'(1);
    we        = (state == S_LINEAR) || (state == S_WAIT);
    rd_en     = (state == S_FILL);
    waddr     = AW'(e) * AW'(ROW) + AW'(n);
    raddr_a   = AW'(e - EW'(1)) * AW'(ROW) + AW'(f - FW'(1));
    raddr_b   = AW'(e) * AW'(ROW) + AW'(n - f);
    worst     = (rdata_a > rdata_b) ? ({1'b0, rdata_a} + (TRIAL_W+1)'(1))
                                    : ({1'b0, rdata_b} + (TRIAL_W+1)'(1));
    best_cand = (rd_vld && (worst < best)) ? worst : best;
    wdata     = (state == S_LINEAR) ? TRIAL_W'(n) : best_cand[TRIAL_W-1:0];
  end

  assign status.busy = (state != S_IDLE);
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      done   <= (state == S_WAIT) && (n == floors) && (e == eggs);
      rd_vld <= (state == S_FILL);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            floors <= floors_in;
            eggs   <= eggs_in;
            e      <= EW'(1);
            n      <= '0;
            state  <= S_LINEAR;
          end
        end
        S_LINEAR: begin
          if (n == lin_end) begin
            if (e == EW'(1)) begin
              e <= EW'(2);
              n <= '0;
            end else begin
              n     <= FW'(2);
              f     <= FW'(1);
              best  <= '1;
              state <= S_FILL;
            end
          end else begin
            n <= n + FW'(1);
          end
        end
        S_FILL: begin
          best <= best_cand;
          if (f == n) begin
            state <= S_WAIT;
          end else begin
            f <= f + FW'(1);
          end
        end
        S_WAIT: begin
          if (n == floors) begin
            if (e == eggs) begin
              trials <= best_cand[TRIAL_W-1:0];
              state  <= S_IDLE;
            end else begin
              e     <= e + EW'(1);
              n     <= '0;
              state <= S_LINEAR;
            end
          end else begin
            n     <= n + FW'(1);
            f     <= FW'(1);
            best  <= '1;
            state <= S_FILL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no write may land on the cycle a read pair is issued
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    we |-> !rd_en)
    else $error("table write overlaps read");

  a_f_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (f >= FW'(1)) && (f <= n))
    else $error("drop floor out of range");

  // an entry for n floors never needs more than n drops
  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (32'(best_cand) <= 32'(n)))
    else $error("minimum exceeds floor count");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == S_IDLE))
    else $error("start while busy");

  a_done_from_wait: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_WAIT) && (state == S_IDLE))
    else $error("done outside final write");
`endif

endmodule

// ===== hdl/egg_drop_min_trials.sv =====
// channel | signals                              | beat
// query   | query_valid, query_ready, query      | floor_count, egg_count
// result  | result_valid, result_ready, result   | min_trials, invalid
//
// trivial queries (0 or 1 floor, one egg, invalid) go via the pending register to result
// a solved query fills the drop table row by row for eggs 2 up to its egg count,
//   one table read pair per drop floor
// rst is synchronous; the table needs no clearing, every entry is written before it is read
// a new query is taken while the previous result waits in the output register
module egg_drop_min_trials import edmt_pkg::*; #(
  parameter int unsigned MAX_FLOORS = 1023,
  parameter int unsigned MAX_EGGS   = 15
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  output logic    query_ready,
  input  query_t  query,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int FW = $clog2(int'(MAX_FLOORS) + 1);
  localparam int EW = $clog2(int'(MAX_EGGS) + 1);

  typedef enum logic [1:0] {T_IDLE, T_SOLVE, T_HOLD} state_t;

  state_t             state;
  result_t            pending;
  result_t            quick;
  logic               need_solve;
  logic               start;
  eng_status_t        eng_status;
  logic [TRIAL_W-1:0] eng_trials;

  always_comb begin
    quick      = '0;
    need_solve = 1'b0;
    if (query.floor_count == '0) begin
      quick.min_trials = '0;
    end else if (query.floor_count == FLOOR_W'(1)) begin
      quick.min_trials = TRIAL_W'(1);
    end else if ((query.egg_count == '0) ||
                 (32'(query.floor_count) > 32'(MAX_FLOORS)) ||
                 (32'(query.egg_count) > 32'(MAX_EGGS))) begin
      quick.invalid = 1'b1;
    end else if (query.egg_count == EGG_W'(1)) begin
      quick.min_trials = TRIAL_W'(query.floor_count);
    end else begin
      need_solve = 1'b1;
    end
  end

  assign query_ready = (state == T_IDLE);
  assign start       = query_valid && query_ready && need_solve;

  edmt_engine #(
    .MAX_FLOORS (MAX_FLOORS),
    .MAX_EGGS   (MAX_EGGS),
    .FW         (FW),
    .EW         (EW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .floors_in (FW'(query.floor_count)),
    .eggs_in   (EW'(query.egg_count)),
    .status    (eng_status),
    .trials    (eng_trials)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != T_HOLD)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (query_valid) begin
            if (need_solve) begin
              state <= T_SOLVE;
            end else begin
              pending <= quick;
              state   <= T_HOLD;
            end
          end
        end
        T_SOLVE: begin
          if (eng_status.done) begin
            pending.min_trials <= eng_trials;
            pending.invalid    <= 1'b0;
            state              <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (!result_valid || result_ready) begin
            result       <= pending;
            result_valid <= 1'b1;
            state        <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_engine_busy_in_solve: assert property (@(posedge clk) disable iff (rst)
    (state == T_SOLVE) && $past(state == T_SOLVE) |-> eng_status.busy || eng_status.done)
    else $error("engine idle while solving");

  a_done_only_in_solve: assert property (@(posedge clk) disable iff (rst)
    eng_status.done |-> (state == T_SOLVE))
    else $error("engine result with no query pending");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.invalid |-> (result.min_trials == '0))
    else $error("invalid result carries a count");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import edmt_pkg::*;

  localparam int unsigned FLOOR_LIMIT    = 1023;
  localparam int unsigned EGG_LIMIT      = 15;
  localparam int unsigned RANDOM_QUERIES = 80;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DRAIN_CYCLES   = 50;
  localparam longint unsigned CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    query_t  q;
    logic    typed;
    result_t answer;
  } vector_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    query_valid = 1'b0;
  logic    query_ready;
  query_t  query = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  result_t         expected_answers [$];
  logic [TRIAL_W-1:0] drops_tbl [0:EGG_LIMIT][0:FLOOR_LIMIT];
  int unsigned     errors, queries_sent, results_checked, table_queries, invalid_seen;
  int unsigned     burst_left, gap_left;
  longint unsigned cycles;
  bit              held_long;

  egg_drop_min_trials #(
    .MAX_FLOORS(FLOOR_LIMIT),
    .MAX_EGGS  (EGG_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_ready (query_ready),
    .query       (query),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic result_t fewest_drops(query_t q);
    result_t     r;
    int unsigned n, e, k, ee, f, best, worst, below, above;
    r = '0;
    n = 32'(q.floor_count);
    e = 32'(q.egg_count);
    if (n == 0) begin
      r.min_trials = '0;
    end else if (n == 1) begin
      r.min_trials = TRIAL_W'(1);
    end else if (e == 0 || n > FLOOR_LIMIT || e > EGG_LIMIT) begin
      r.invalid = 1'b1;
    end else if (e == 1) begin
      r.min_trials = TRIAL_W'(n);
    end else begin
      for (k = 0; k <= n; k++) drops_tbl[1][k] = TRIAL_W'(k);
      for (ee = 2; ee <= e; ee++) begin
        drops_tbl[ee][0] = '0;
        drops_tbl[ee][1] = TRIAL_W'(1);
        for (k = 2; k <= n; k++) begin
          best = '1;
          for (f = 1; f <= k; f++) begin
            below = 32'(drops_tbl[ee-1][f-1]);
            above = 32'(drops_tbl[ee][k-f]);
            worst = 1 + ((below > above) ? below : above);
            if (worst < best) best = worst;
          end
          drops_tbl[ee][k] = TRIAL_W'(best);
        end
      end
      r.min_trials = drops_tbl[e][n];
    end
    return r;
  endfunction

  function automatic vector_t row(int unsigned n, int unsigned e, bit typed = 1'b0,
                                  int unsigned trials = 0, bit bad = 1'b0);
    vector_t v;
    v.q.floor_count    = FLOOR_W'(n);
    v.q.egg_count      = EGG_W'(e);
    v.typed            = typed;
    v.answer.min_trials = TRIAL_W'(trials);
    v.answer.invalid   = bad;
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic offer(input vector_t v);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap_left != 0) begin
      query_valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    query_valid <= 1'b1;
    query       <= v.q;
    do @(posedge clk); while (!query_ready);
    expected_answers.push_back(v.typed ? v.answer : fewest_drops(v.q));
    if (v.q.floor_count >= 2 && v.q.egg_count >= 2) table_queries++;
    queries_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got trials=%0d invalid=%0b",
                 $time, result.min_trials, result.invalid);
      end else begin
        want = expected_answers.pop_front();
        if (result.min_trials !== want.min_trials || result.invalid !== want.invalid) begin
          errors++;
          $display("%0t: mismatch, expected trials=%0d invalid=%0b, got trials=%0d invalid=%0b",
                   $time, want.min_trials, want.invalid, result.min_trials, result.invalid);
        end
      end
      results_checked++;
      if (result.invalid) invalid_seen++;
    end
  end

  initial begin : rx_pattern
    int unsigned mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      // one long hold-off so the result register and query side back up
      if (!held_long && queries_sent >= 40) begin
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held_long = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ($urandom_range(0, 3) != 0);
        2:       result_ready <= ($urandom_range(0, 3) == 0);
        default: result_ready <= (left % 5 >= 2);
      endcase
    end
  end

  initial begin : stimulus
    vector_t     directed [$];
    vector_t     v;
    int unsigned i, kind;
    directed.push_back(row(0, 0, 1, 0, 0));
    directed.push_back(row(0, 15, 1, 0, 0));
    directed.push_back(row(1, 0, 1, 1, 0));
    directed.push_back(row(1, 15, 1, 1, 0));
    directed.push_back(row(2, 0, 1, 0, 1));
    directed.push_back(row(1023, 0, 1, 0, 1));
    directed.push_back(row(682, 0, 1, 0, 1));
    directed.push_back(row(341, 1, 1, 341, 0));
    directed.push_back(row(1023, 1, 1, 1023, 0));
    directed.push_back(row(2, 1, 1, 2, 0));
    directed.push_back(row(2, 2));
    directed.push_back(row(2, 15));
    directed.push_back(row(3, 2));
    directed.push_back(row(10, 3));
    directed.push_back(row(36, 2));
    directed.push_back(row(100, 2));
    directed.push_back(row(21, 15));
    directed.push_back(row(6, 10));
    directed.push_back(row(9, 5));
    directed.push_back(row(1023, 2));

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[j]) offer(directed[j]);

    for (i = 0; i < RANDOM_QUERIES; i++) begin
      // keep queries cheap around the long hold-off so the input really stalls
      if (queries_sent >= 36 && queries_sent < 52) kind = $urandom_range(0, 2);
      else kind = $urandom_range(0, 15);
      case (kind)
        0:       v = row($urandom_range(0, 1), $urandom_range(0, 15));
        1:       v = row($urandom_range(0, 1023), 0);
        2:       v = row($urandom_range(0, 1023), 1);
        3:       v = row($urandom_range(2, 120), $urandom_range(2, 3));
        default: v = row($urandom_range(2, 31), $urandom_range(2, 15));
      endcase
      offer(v);
    end
    query_valid <= 1'b0;

    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d queries sent, %0d solved through the drop table, %0d results checked",
             queries_sent, table_queries, results_checked);
    $display("%0d answers flagged invalid, one %0d-cycle result hold-off",
             invalid_seen, LONG_HOLD);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
